/* rtl/core/tlfe_pkg.sv */
// Shared constants, codes and types of the touch LED fade engine.
package tlfe_pkg;

	localparam int SEGMENTS         = 4;
	localparam int LEDS_PER_SEGMENT = 32;
	localparam int NOTES            = 32;
	localparam int TOTAL_LEDS       = SEGMENTS * LEDS_PER_SEGMENT;
	localparam int GROUP            = TOTAL_LEDS / NOTES;
	localparam int IDX_W            = $clog2(TOTAL_LEDS);
	localparam int CNT_W            = $clog2(LEDS_PER_SEGMENT);

	// payload field widths
	localparam int OPC_W   = 2;
	localparam int STEP_W  = 8;
	localparam int POS_W   = 13;
	localparam int NOTE_W  = 5;
	localparam int VEL_W   = 7;
	localparam int SEG_W   = 2;
	localparam int LED_W   = 5;
	localparam int STR_W   = 12;
	localparam int LEVEL_W = 10;
	localparam int TIME_W  = 32;
	localparam int FI_W    = 8;
	localparam int BGS_W   = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int FRAC_UNIT    = 50;
	localparam int TOUCH_LIMIT  = TOTAL_LEDS * FRAC_UNIT;
	localparam int TOUCH_STEPS  = 4;
	localparam int TW_BASE      = 100;
	localparam int TW_TOP       = 199;
	// pos = (position * DIV_MUL) >> DIV_SHIFT is exact below 43690
	localparam int DIV_MUL      = 5243;
	localparam int DIV_SHIFT    = 18;
	localparam int LEVEL_MAX    = 1023;
	localparam int STRENGTH_MAX = 4000;
	localparam int STRENGTH_MUL = 20;
	localparam int BG_PERIOD    = 64;
	localparam int BG_PH_W      = $clog2(BG_PERIOD);

	localparam logic [FI_W-1:0]  FADE_INTERVAL_RST = 8'd4;
	localparam logic [BGS_W-1:0] BG_SPEED_RST      = 4'd4;

	// input opcodes
	localparam logic [OPC_W-1:0] OPC_FRAME   = 2'd0;
	localparam logic [OPC_W-1:0] OPC_TOUCH   = 2'd1;
	localparam logic [OPC_W-1:0] OPC_NOTE    = 2'd2;
	localparam logic [OPC_W-1:0] OPC_REFRESH = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FADE_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG_SPEED      = 2'd1;

	// touch sub-steps, in the order the weights are applied
	localparam logic [1:0] TK_UP0 = 2'd0;
	localparam logic [1:0] TK_DN0 = 2'd1;
	localparam logic [1:0] TK_UP1 = 2'd2;
	localparam logic [1:0] TK_DN1 = 2'd3;

	// datapath step commands
	localparam int STEPC_W = 4;
	localparam logic [STEPC_W-1:0] STEP_NONE  = 4'd0;
	localparam logic [STEPC_W-1:0] STEP_LOAD  = 4'd1;
	localparam logic [STEPC_W-1:0] STEP_FRAME = 4'd2;
	localparam logic [STEPC_W-1:0] STEP_TDIV  = 4'd3;
	localparam logic [STEPC_W-1:0] STEP_TFRAC = 4'd4;
	localparam logic [STEPC_W-1:0] STEP_TRD   = 4'd5;
	localparam logic [STEPC_W-1:0] STEP_TWR   = 4'd6;
	localparam logic [STEPC_W-1:0] STEP_NRD   = 4'd7;
	localparam logic [STEPC_W-1:0] STEP_NWR   = 4'd8;
	localparam logic [STEPC_W-1:0] STEP_RBG   = 4'd9;
	localparam logic [STEPC_W-1:0] STEP_RLED  = 4'd10;
	localparam logic [STEPC_W-1:0] STEP_REND  = 4'd11;

	typedef struct packed {
		logic [STEPC_W-1:0] step;
		logic [CNT_W-1:0]   cnt;
	} ctl_t;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic             touch_ok;
		logic             note_ok;
		logic             tstep_ok;
		logic             led_adv;
		logic             out_free;
	} stat_t;

	typedef struct packed {
		logic [SEG_W-1:0] segment;
		logic [LED_W-1:0] led;
		logic [STR_W-1:0] strength;
		logic             last;
	} wr_item_t;

endpackage

/* rtl/core/tlfe_if.sv */
// Channel interfaces: input items, LED write items and register writes.
interface tlfe_req_if;
	import tlfe_pkg::*;
	logic              valid;
	logic              ready;
	logic [OPC_W-1:0]  opcode;
	logic [STEP_W-1:0] time_step;
	logic [POS_W-1:0]  touch_position;
	logic [NOTE_W-1:0] note_index;
	logic [VEL_W-1:0]  note_velocity;

	modport source (output valid, opcode, time_step, touch_position, note_index,
		note_velocity, input ready);
	modport sink (input valid, opcode, time_step, touch_position, note_index,
		note_velocity, output ready);
endinterface

interface tlfe_wr_if;
	import tlfe_pkg::*;
	logic             valid;
	logic             ready;
	logic [SEG_W-1:0] segment;
	logic [LED_W-1:0] led;
	logic [STR_W-1:0] strength;
	logic             last;

	modport source (output valid, segment, led, strength, last, input ready);
	modport sink (input valid, segment, led, strength, last, output ready);
endinterface

interface tlfe_cfg_if;
	import tlfe_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/tlfe_ctrl.sv */
// Sequencer of the fade engine: decodes items and steps the datapath.
module tlfe_ctrl import tlfe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  stat_t stat,
	output ctl_t  ctl
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_TDIV   = 4'd2;
	localparam logic [3:0] S_TFRAC  = 4'd3;
	localparam logic [3:0] S_TRD    = 4'd4;
	localparam logic [3:0] S_TWR    = 4'd5;
	localparam logic [3:0] S_NRD    = 4'd6;
	localparam logic [3:0] S_NWR    = 4'd7;
	localparam logic [3:0] S_RBG    = 4'd8;
	localparam logic [3:0] S_RLED   = 4'd9;
	localparam logic [3:0] S_REND   = 4'd10;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ctl.cnt = cnt_q;
		ctl.step = STEP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.step = STEP_LOAD;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cnt_d = '0;
				unique case (stat.opcode)
					OPC_FRAME: begin
						ctl.step = STEP_FRAME;
						state_d  = S_IDLE;
					end
					OPC_TOUCH:   state_d = stat.touch_ok ? S_TDIV : S_IDLE;
					OPC_NOTE:    state_d = stat.note_ok ? S_NRD : S_IDLE;
					OPC_REFRESH: state_d = S_RBG;
					default:     state_d = S_IDLE;
				endcase
			end
			S_TDIV: begin
				ctl.step = STEP_TDIV;
				state_d  = S_TFRAC;
			end
			S_TFRAC: begin
				ctl.step = STEP_TFRAC;
				cnt_d    = '0;
				state_d  = S_TRD;
			end
			S_TRD: begin
				ctl.step = STEP_TRD;
				if (stat.tstep_ok) begin
					state_d = S_TWR;
				end else if (cnt_q == CNT_W'(TOUCH_STEPS - 1)) begin
					state_d = S_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_TWR: begin
				ctl.step = STEP_TWR;
				if (cnt_q == CNT_W'(TOUCH_STEPS - 1)) begin
					state_d = S_IDLE;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = S_TRD;
				end
			end
			S_NRD: begin
				ctl.step = STEP_NRD;
				state_d  = S_NWR;
			end
			S_NWR: begin
				ctl.step = STEP_NWR;
				if (cnt_q == CNT_W'(GROUP - 1)) begin
					state_d = S_IDLE;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = S_NRD;
				end
			end
			S_RBG: begin
				ctl.step = STEP_RBG;
				cnt_d    = '0;
				state_d  = S_RLED;
			end
			S_RLED: begin
				ctl.step = STEP_RLED;
				if (stat.led_adv) begin
					if (cnt_q == CNT_W'(LEDS_PER_SEGMENT - 1)) state_d = S_REND;
					else cnt_d = cnt_q + 1'b1;
				end
			end
			S_REND: begin
				ctl.step = STEP_REND;
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_led_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RLED && stat.led_adv && cnt_q == CNT_W'(LEDS_PER_SEGMENT - 1))
		|=> state_q == S_REND)
		else $error("refresh walk did not close after the last LED");

	a_twr_after_trd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TWR |-> $past(state_q) == S_TRD && $past(stat.tstep_ok))
		else $error("touch write without a valid read step");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> state_q == S_DECODE)
		else $error("accepted item not decoded");

endmodule

/* rtl/core/tlfe_dpath.sv */
// Datapath: level memories, timing state, touch/note math and write staging.
module tlfe_dpath import tlfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl,
	output stat_t             stat,
	input  logic [OPC_W-1:0]  opcode,
	input  logic [STEP_W-1:0] time_step,
	input  logic [POS_W-1:0]  touch_position,
	input  logic [NOTE_W-1:0] note_index,
	input  logic [VEL_W-1:0]  note_velocity,
	tlfe_cfg_if.sink          cfg,
	tlfe_wr_if.source         wr
);

	// latched item
	logic [OPC_W-1:0]  opc_q;
	logic [STEP_W-1:0] tstep_q;
	logic [POS_W-1:0]  tpos_q;
	logic [NOTE_W-1:0] note_q;
	logic [VEL_W-1:0]  vel_q;

	logic [FI_W-1:0]   fade_int_q;
	logic [BGS_W-1:0]  bg_shift_q;
	logic [TIME_W-1:0] rtime_q;
	logic [SEG_W-1:0]  seg_q;
	logic [TIME_W-1:0] mark_q [SEGMENTS];
	logic [CNT_W-1:0]  bgp_q [SEGMENTS];
	logic              fade_q;

	logic [IDX_W-1:0]  lpos_q;
	logic [VEL_W-1:0]  frac_q;

	logic [LEVEL_W-1:0]    tgt_mem [TOTAL_LEDS];
	logic [LEVEL_W-1:0]    dsp_mem [TOTAL_LEDS];
	logic [TOTAL_LEDS-1:0] tvalid_q, dvalid_q;
	logic [LEVEL_W-1:0]    tdat_q, ddat_q;
	logic                  tv_q, dv_q;

	logic     out_valid_q;
	wr_item_t out_q, pend_q;

	assign cfg.ready = 1'b1;

	// touch position split
	logic [POS_W+POS_W-1:0] div_prod;
	logic [IDX_W-1:0]       div_q;
	logic [POS_W-1:0]       rem;
	assign div_prod = (POS_W + POS_W)'(tpos_q) * (POS_W + POS_W)'(DIV_MUL);
	assign div_q    = div_prod[DIV_SHIFT +: IDX_W];
	assign rem      = tpos_q - POS_W'(lpos_q) * POS_W'(FRAC_UNIT);

	logic [IDX_W:0] lpos_x, taddr_x;
	logic [7:0]     tw;
	logic           tstep_ok;
	assign lpos_x = {1'b0, lpos_q};

	always_comb begin
		unique case (ctl.cnt[1:0])
			TK_UP0: begin
				taddr_x  = lpos_x + (IDX_W + 1)'(1);
				tw       = {1'b0, frac_q} + 8'(TW_BASE);
				tstep_ok = taddr_x < (IDX_W + 1)'(TOTAL_LEDS);
			end
			TK_DN0: begin
				taddr_x  = lpos_x;
				tw       = 8'(TW_TOP) - {1'b0, frac_q};
				tstep_ok = 1'b1;
			end
			TK_UP1: begin
				taddr_x  = lpos_x + (IDX_W + 1)'(2);
				tw       = {1'b0, frac_q};
				tstep_ok = taddr_x < (IDX_W + 1)'(TOTAL_LEDS);
			end
			TK_DN1: begin
				taddr_x  = lpos_x - (IDX_W + 1)'(1);
				tw       = 8'(TW_TOP - TW_BASE) - {1'b0, frac_q};
				tstep_ok = lpos_q != '0;
			end
			default: begin
				taddr_x  = lpos_x;
				tw       = '0;
				tstep_ok = 1'b0;
			end
		endcase
	end

	logic [IDX_W-1:0] naddr;
	assign naddr = IDX_W'(int'(note_q) * GROUP + int'(ctl.cnt));

	// current read data, never-written entries read as zero
	logic [LEVEL_W-1:0] tval, dval;
	assign tval = tv_q ? tdat_q : '0;
	assign dval = dv_q ? ddat_q : '0;

	logic [LEVEL_W:0]   tsum;
	logic [LEVEL_W-1:0] tsat, tmax;
	assign tsum = {1'b0, tval} + (LEVEL_W + 1)'(tw);
	assign tsat = (tsum > (LEVEL_W + 1)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : tsum[LEVEL_W-1:0];
	assign tmax = (LEVEL_W'(vel_q) > tval) ? LEVEL_W'(vel_q) : tval;

	// refresh LED update
	logic [IDX_W-1:0]   base, cur, nxt;
	logic               active, out_free, led_adv;
	logic [LEVEL_W+1:0] dec3;
	logic [LEVEL_W-1:0] nd;
	logic [14:0]        s20;
	logic [STR_W-1:0]   led_str;

	assign base   = IDX_W'(int'(seg_q) * LEDS_PER_SEGMENT);
	assign cur    = base + IDX_W'(ctl.cnt);
	assign nxt    = cur + 1'b1;
	assign active = (tval != '0) || (dval != '0);
	assign dec3   = (LEVEL_W + 2)'(dval - tval) * (LEVEL_W + 2)'(3);

	always_comb begin
		if (tval > dval) nd = tval;
		else if (fade_q) nd = dec3[LEVEL_W+1:2] + tval;
		else nd = dval;
	end

	assign s20      = 15'(nd) * 15'(STRENGTH_MUL);
	assign led_str  = (s20 > 15'(STRENGTH_MAX)) ? STR_W'(STRENGTH_MAX) : s20[STR_W-1:0];
	assign out_free = !out_valid_q || wr.ready;
	assign led_adv  = !active || out_free;

	// background and fade decision
	logic [CNT_W-1:0]   bp_cur;
	logic [TIME_W-1:0]  tdiff, tsh;
	logic               fade_now;
	logic [BG_PH_W-1:0] ph;
	logic [STR_W-1:0]   bg_str;

	assign bp_cur   = bgp_q[seg_q];
	assign tdiff    = rtime_q - mark_q[seg_q];
	assign fade_now = tdiff > TIME_W'(fade_int_q);
	assign tsh      = rtime_q >> bg_shift_q;
	assign ph       = tsh[BG_PH_W-1:0] + BG_PH_W'({bp_cur, 2'b00});
	assign bg_str   = ph[BG_PH_W-1] ? STR_W'((BG_PH_W + 1)'(BG_PERIOD) - (BG_PH_W + 1)'(ph))
	                                : STR_W'(ph);

	// memory addressing
	logic [IDX_W-1:0]   rd_addr, t_waddr;
	logic [LEVEL_W-1:0] t_wdata;
	logic               t_we, d_we;

	always_comb begin
		unique case (ctl.step)
			STEP_TRD:  rd_addr = taddr_x[IDX_W-1:0];
			STEP_NRD:  rd_addr = naddr;
			STEP_RBG:  rd_addr = base;
			STEP_RLED: rd_addr = led_adv ? nxt : cur;
			default:   rd_addr = cur;
		endcase
	end

	assign t_we    = (ctl.step == STEP_TWR) || (ctl.step == STEP_NWR);
	assign t_waddr = (ctl.step == STEP_TWR) ? taddr_x[IDX_W-1:0] : naddr;
	assign t_wdata = (ctl.step == STEP_TWR) ? tsat : tmax;
	assign d_we    = (ctl.step == STEP_RLED) && led_adv && active;

	logic push_led, push_end;
	assign push_led = (ctl.step == STEP_RLED) && active && out_free;
	assign push_end = (ctl.step == STEP_REND) && out_free;

	assign stat.opcode   = opc_q;
	assign stat.touch_ok = 32'(tpos_q) < TOUCH_LIMIT;
	assign stat.note_ok  = (vel_q != '0) && (int'(note_q) < NOTES);
	assign stat.tstep_ok = tstep_ok;
	assign stat.led_adv  = led_adv;
	assign stat.out_free = out_free;

	always_ff @(posedge clk) begin
		if (ctl.step == STEP_LOAD) begin
			opc_q   <= opcode;
			tstep_q <= time_step;
			tpos_q  <= touch_position;
			note_q  <= note_index;
			vel_q   <= note_velocity;
		end
		if (ctl.step == STEP_TDIV) lpos_q <= div_q;
		if (ctl.step == STEP_TFRAC) frac_q <= {rem[VEL_W-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (t_we) tgt_mem[t_waddr] <= t_wdata;
		if (d_we) dsp_mem[cur] <= nd;
		tdat_q <= tgt_mem[rd_addr];
		ddat_q <= dsp_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= '0;
			dvalid_q <= '0;
			tv_q     <= 1'b0;
			dv_q     <= 1'b0;
		end else begin
			if (ctl.step == STEP_FRAME) tvalid_q <= '0;
			else if (t_we) tvalid_q[t_waddr] <= 1'b1;
			if (d_we) dvalid_q[cur] <= 1'b1;
			tv_q <= tvalid_q[rd_addr];
			dv_q <= dvalid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_int_q <= FADE_INTERVAL_RST;
			bg_shift_q <= BG_SPEED_RST;
			rtime_q    <= '0;
			seg_q      <= '0;
			fade_q     <= 1'b0;
			for (int s = 0; s < SEGMENTS; s++) begin
				mark_q[s] <= '0;
				bgp_q[s]  <= '0;
			end
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_FADE_INTERVAL: fade_int_q <= cfg.data;
					REG_BG_SPEED:      bg_shift_q <= cfg.data[BGS_W-1:0];
					default: ;
				endcase
			end
			if (ctl.step == STEP_FRAME) rtime_q <= rtime_q + TIME_W'(tstep_q);
			if (ctl.step == STEP_RBG) begin
				fade_q <= fade_now;
				if (fade_now) mark_q[seg_q] <= mark_q[seg_q] + TIME_W'(fade_int_q);
				bgp_q[seg_q] <= (bp_cur == CNT_W'(LEDS_PER_SEGMENT - 1)) ? '0
				                                                       : bp_cur + 1'b1;
			end
			if (push_end)
				seg_q <= (seg_q == SEG_W'(SEGMENTS - 1)) ? '0 : seg_q + 1'b1;
		end
	end

	// the newest write waits in pend_q until it is known whether it is the last one
	always_ff @(posedge clk) begin
		if (ctl.step == STEP_RBG) begin
			pend_q.segment  <= seg_q;
			pend_q.led      <= LED_W'(bp_cur);
			pend_q.strength <= bg_str;
			pend_q.last     <= 1'b0;
		end else if (push_led) begin
			pend_q.segment  <= seg_q;
			pend_q.led      <= LED_W'(ctl.cnt);
			pend_q.strength <= led_str;
			pend_q.last     <= 1'b0;
		end
		if (push_led) begin
			out_q <= pend_q;
		end else if (push_end) begin
			out_q      <= pend_q;
			out_q.last <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (push_led || push_end) out_valid_q <= 1'b1;
		else if (wr.ready) out_valid_q <= 1'b0;
	end

	assign wr.valid    = out_valid_q;
	assign wr.segment  = out_q.segment;
	assign wr.led      = out_q.led;
	assign wr.strength = out_q.strength;
	assign wr.last     = out_q.last;

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		d_we |-> cur != rd_addr)
		else $error("display write hits the address being read ahead");

	a_strength_cap: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid |-> wr.strength <= STR_W'(STRENGTH_MAX))
		else $error("strength above cap");

	a_end_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		push_end |=> out_valid_q && out_q.last)
		else $error("refresh end did not present a last write");

endmodule

/* rtl/core/touch_led_fade_engine.sv */
// Top level of the touch LED fade engine: sequencer plus datapath.
// Items are taken one at a time. A frame start is a load and a decode step; a touch
// splits the position by reciprocal multiply, then does up to four read-modify-write
// steps on the target memory; a note does one read-modify-write per LED of the group.
// A refresh, which waits while the LED write channel stalls, has a step for the
// background LED, then one per LED of the segment (the level memories are read one
// LED ahead and written in the same cycle), and a closing step that flags the last
// write. Results go out through a single output register; the most recent write is
// held back one slot so that the final one carries last. Target and display levels
// sit in 128-entry memories with per-entry valid bits, so neither reset nor frame
// start needs a clearing pass.
module touch_led_fade_engine import tlfe_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	tlfe_req_if.sink  req,
	tlfe_wr_if.source wr,
	tlfe_cfg_if.sink  cfg
);

	ctl_t  ctl;
	stat_t stat;
	logic  req_ready;

	assign req.ready = req_ready;

	tlfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	tlfe_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.opcode         (req.opcode),
		.time_step      (req.time_step),
		.touch_position (req.touch_position),
		.note_index     (req.note_index),
		.note_velocity  (req.note_velocity),
		.cfg            (cfg),
		.wr             (wr)
	);

endmodule
